[hw/rtl/crcc_pkg.sv]
`default_nettype none

package crcc_pkg;

  // reflected crc-32 constants
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // record length limits in bytes
  localparam logic [8:0] LEN_MIN   = 9'd8;
  localparam logic [8:0] LEN_MAX   = 9'd256;
  localparam logic [8:0] LEN_RESET = 9'd48;
  localparam logic [8:0] CRC_FIELD_BYTES = 9'd4;
  localparam logic [8:0] MAGIC_BYTES     = 9'd4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAGIC_WORD   = 2'd0,
    REG_RECORD_BYTES = 2'd1
  } reg_index_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/config_record_crc_checker_unit.sv]
`default_nettype none

// Checks a configuration record that arrives one byte per word on the s_ side,
// in memory order. The first four bytes form the magic word and the last four
// the stored crc, both little-endian; a reflected crc-32 runs over every byte
// but the last four. One byte is taken every cycle; after the final byte of a
// record one result word appears on the m_ side on the next cycle, held in a
// single output register, so the input only stalls while that register holds
// a word the sink has not taken. record_bytes sets the length (clamped to
// 8..256) and a new value takes effect on the next byte. No clearing pass.
module config_record_crc_checker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // record bytes in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  // result words out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [31:0] computed_crc, [32] magic_ok,
                                      // [33] crc_ok, [34] record_valid, [39:35] zero
);

  // configuration registers
  logic [31:0] magic_word;
  logic [8:0]  record_bytes;

  // record state
  logic [8:0]  byte_position;
  logic [31:0] crc_running;
  logic [31:0] magic_captured;
  logic [31:0] stored_crc_captured;

  // output register
  logic [31:0] out_crc;
  logic        out_magic_ok;
  logic        out_crc_ok;
  logic        out_record_valid;

  // per-byte logic
  logic        in_fire;
  logic [8:0]  len_eff;
  logic [8:0]  crc_end;
  logic        last_byte;
  logic        in_magic;
  logic        in_crc_span;
  logic [31:0] crc_next;
  logic [31:0] magic_next;
  logic [31:0] stored_next;
  logic [31:0] computed;

  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word   <= '0;
      record_bytes <= crcc_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crcc_pkg::REG_MAGIC_WORD:   magic_word   <= cfg_data;
        crcc_pkg::REG_RECORD_BYTES: record_bytes <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // take a byte whenever the output register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // clamp the length and locate the byte
  always_comb begin
    if (record_bytes < crcc_pkg::LEN_MIN) begin
      len_eff = crcc_pkg::LEN_MIN;
    end else if (record_bytes > crcc_pkg::LEN_MAX) begin
      len_eff = crcc_pkg::LEN_MAX;
    end else begin
      len_eff = record_bytes;
    end
    crc_end     = len_eff - crcc_pkg::CRC_FIELD_BYTES;
    last_byte   = ({1'b0, byte_position} + 10'd1) >= {1'b0, len_eff};
    in_magic    = byte_position < crcc_pkg::MAGIC_BYTES;
    in_crc_span = byte_position < crc_end;
  end

  // next record state for this byte
  always_comb begin
    magic_next = magic_captured;
    if (in_magic) begin
      magic_next = magic_captured | ({24'd0, s_tdata} << {byte_position[1:0], 3'b000});
    end
    crc_next    = crc_running;
    stored_next = stored_crc_captured;
    if (in_crc_span) begin
      crc_next = crcc_pkg::crc_byte(crc_running, s_tdata);
    end else begin
      stored_next = {s_tdata, stored_crc_captured[31:8]};
    end
    computed = crc_running ^ crcc_pkg::CRC_ALL_ONES;
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      crc_running         <= crcc_pkg::CRC_ALL_ONES;
      magic_captured      <= '0;
      stored_crc_captured <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        byte_position       <= '0;
        crc_running         <= crcc_pkg::CRC_ALL_ONES;
        magic_captured      <= '0;
        stored_crc_captured <= '0;
      end else begin
        byte_position       <= byte_position + 9'd1;
        crc_running         <= crc_next;
        magic_captured      <= magic_next;
        stored_crc_captured <= stored_next;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      out_crc          <= computed;
      out_magic_ok     <= magic_next == magic_word;
      out_crc_ok       <= stored_next == computed;
      out_record_valid <= (magic_next == magic_word) && (stored_next == computed);
    end
  end

  assign m_tdata = {5'd0, out_record_valid, out_crc_ok, out_magic_ok, out_crc};

  // position never runs past the longest record
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position < crcc_pkg::LEN_MAX)
    else $error("byte position out of range");

  // a final byte restarts the record
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> byte_position == 9'd0 &&
      crc_running == crcc_pkg::CRC_ALL_ONES)
    else $error("record did not restart after final byte");

  // other bytes advance the position by one
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_byte |=> byte_position == $past(byte_position) + 9'd1)
    else $error("byte position did not advance");

  // overall flag agrees with both checks
  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34] == (m_tdata[32] && m_tdata[33]))
    else $error("record_valid disagrees with magic and crc checks");

endmodule

`default_nettype wire

[test/record_check_monitor.sv]
package record_crc_tb_pkg;
  import crcc_pkg::*;

  // reflected crc-32, one data bit per pass, lsb first
  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // record length as the block uses it, clamped to 8..256
  function automatic int effective_len(input logic [8:0] n);
    if (n < LEN_MIN) return LEN_MIN;
    if (n > LEN_MAX) return LEN_MAX;
    return n;
  endfunction

endpackage

module record_check_monitor
  import crcc_pkg::*;
  import record_crc_tb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  output int               pending,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] crc;
    logic        magic_ok;
    logic        crc_ok;
    logic        record_valid;
  } verdict_t;

  // register copies
  logic [31:0] magic_reg;
  logic [8:0]  length_reg;

  // record in progress
  logic [8:0]  pos;
  logic [31:0] crc_acc;
  logic [31:0] magic_acc;
  logic [31:0] stored_acc;

  verdict_t verdict_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic clear_record();
    pos        = '0;
    crc_acc    = CRC_ALL_ONES;
    magic_acc  = '0;
    stored_acc = '0;
  endtask

  // fold one accepted byte into the record, queue a verdict on the final byte
  task automatic absorb_byte(input logic [7:0] b);
    int       len;
    verdict_t v;
    len = effective_len(length_reg);
    if (pos < 4) magic_acc = magic_acc | (32'(b) << (8 * pos));
    if (pos < len - 4) begin
      crc_acc = crc32_next(crc_acc, b);
    end else begin
      // trailing bytes shift in from the top
      stored_acc = {b, stored_acc[31:8]};
    end
    if (pos + 1 < len) begin
      pos = pos + 9'd1;
    end else begin
      v.crc          = ~crc_acc;
      v.magic_ok     = (magic_acc == magic_reg);
      v.crc_ok       = (stored_acc == v.crc);
      v.record_valid = v.magic_ok & v.crc_ok;
      verdict_q.push_back(v);
      clear_record();
    end
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      magic_reg  = '0;
      length_reg = LEN_RESET;
      clear_record();
      verdict_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC_WORD:   magic_reg = cfg_data;
          REG_RECORD_BYTES: length_reg = cfg_data[8:0];
          default: ;
        endcase
      end
      // result words against the oldest verdict
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with nothing expected", m_tdata[31:0], '0);
        end else begin
          v = verdict_q.pop_front();
          if (m_tdata[31:0] !== v.crc)
            report_mismatch("computed_crc", m_tdata[31:0], v.crc);
          if (m_tdata[32] !== v.magic_ok)
            report_mismatch("magic_ok", 32'(m_tdata[32]), 32'(v.magic_ok));
          if (m_tdata[33] !== v.crc_ok)
            report_mismatch("crc_ok", 32'(m_tdata[33]), 32'(v.crc_ok));
          if (m_tdata[34] !== v.record_valid)
            report_mismatch("record_valid", 32'(m_tdata[34]), 32'(v.record_valid));
        end
      end
      if (s_tvalid && s_tready) absorb_byte(s_tdata);
    end
    pending <= verdict_q.size();
  end

endmodule

[test/config_record_crc_checker_unit_test.sv]
module config_record_crc_checker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crcc_pkg::*;
  import record_crc_tb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int SEG_BYTES    = 64;

  typedef enum int {REC_GOOD, REC_BAD_MAGIC, REC_BAD_CRC, REC_NOISE} rec_kind_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;
  int          pending;
  int          fail_count;

  int          src_idle = 0;
  int          snk_idle = 0;
  int          quiet_cycles = 0;
  logic [31:0] magic_val = '0;
  logic [8:0]  len_val;
  int          efflen;
  int          open_bytes = 0;
  int          sent;
  int          fill;
  int          pick;

  config_record_crc_checker_unit dut (.*);
  record_check_monitor mon (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink stalls at random
  always @(negedge clk) m_tready <= !rst && ($urandom_range(0, 99) >= snk_idle);

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("config_record_crc_checker_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    logic taken;
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = s_tready;
      @(negedge clk);
    end
  endtask

  // magic first, then record length
  task automatic write_config(input logic [31:0] magic, input logic [31:0] len_word);
    logic taken;
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (r == 0) ? REG_MAGIC_WORD : REG_RECORD_BYTES;
      cfg_data  <= (r == 0) ? magic : len_word;
      taken = 1'b0;
      while (!taken) begin
        @(posedge clk);
        taken = cfg_ready;
        @(negedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // hold off until every verdict has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one record: magic, random payload, crc; optionally spoiled
  task automatic send_record(input int len, input rec_kind_t kind);
    logic [7:0]  rec[$];
    logic [31:0] crc;
    for (int i = 0; i < len - 4; i++) begin
      rec.push_back(i < 4 ? magic_val[8*i +: 8] : 8'($urandom));
    end
    if (kind == REC_BAD_MAGIC) begin
      pick = $urandom_range(0, 3);
      rec[pick] = rec[pick] ^ (8'h01 << $urandom_range(0, 7));
    end
    crc = CRC_ALL_ONES;
    foreach (rec[i]) crc = crc32_next(crc, rec[i]);
    crc = ~crc;
    for (int i = 0; i < 4; i++) rec.push_back(crc[8*i +: 8]);
    if (kind == REC_BAD_CRC) begin
      pick = len - 1 - $urandom_range(0, 3);
      rec[pick] = rec[pick] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (kind == REC_NOISE) begin
      foreach (rec[i]) rec[i] = 8'($urandom);
    end
    foreach (rec[i]) send_byte(rec[i]);
  endtask

  function automatic rec_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return REC_GOOD;
    if (r == 7) return REC_BAD_MAGIC;
    if (r == 8) return REC_BAD_CRC;
    return REC_NOISE;
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    src_idle = 11;
    snk_idle = 84;
    @(negedge clk);

    // directed: shortest records, zero magic, an all-ones record, bad crc
    write_config('0, 32'd8);
    send_record(8, REC_GOOD);
    repeat (8) send_byte(8'hFF);
    send_record(8, REC_BAD_CRC);

    // random segments under three idle mixes
    for (int mode = 0; mode < 3; mode++) begin
      src_idle = (mode == 0) ? 11 : (mode == 1) ? 84 : 0;
      snk_idle = (mode == 0) ? 84 : (mode == 1) ? 11 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0:       magic_val = '0;
          1:       magic_val = '1;
          default: magic_val = $urandom;
        endcase
        case (seg)
          0:       len_val = 9'($urandom_range(0, 7));
          1:       len_val = 9'($urandom_range(9, 40));
          2:       len_val = LEN_RESET;
          3:       len_val = (mode == 0) ? 9'd256 :
                             (mode == 1) ? 9'($urandom_range(257, 511)) : 9'd8;
          default: len_val = 9'($urandom_range(8, 24));
        endcase
        write_config(magic_val, {23'($urandom), len_val});
        efflen = effective_len(len_val);

        // finish a record left open across the length change
        if (open_bytes > 0) begin
          fill = (open_bytes >= efflen) ? 1 : efflen - open_bytes;
          repeat (fill) send_byte(8'($urandom));
          open_bytes = 0;
        end else if (seg == 3) begin
          send_record(efflen, REC_GOOD);
        end

        if (seg != 3) begin
          sent = 0;
          while (sent < SEG_BYTES) begin
            send_record(efflen, pick_kind());
            sent += efflen;
          end
        end

        // leave a record half done before the next length change
        if (seg == 2 && mode != 0) begin
          open_bytes = $urandom_range(10, 47);
          repeat (open_bytes) send_byte(8'($urandom));
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("config_record_crc_checker_unit test passed");
    end else begin
      $display("config_record_crc_checker_unit test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/crcc_pkg.sv
hw/rtl/config_record_crc_checker_unit.sv
test/record_check_monitor.sv
test/config_record_crc_checker_unit_test.sv
